// ===== rtl/ffpc_pkg.sv =====
// Package: command codes and constants for the fast floating point converter.
package ffpc_pkg;
    typedef enum logic [1:0] {
        CMD_S2F = 2'd0,
        CMD_U2F = 2'd1,
        CMD_F2S = 2'd2,
        CMD_F2U = 2'd3
    } t_cmd;

    localparam logic [6:0]  BIAS    = 7'd64;
    localparam logic [6:0]  TOP_EXP = 7'd96;
    localparam logic [31:0] INT_MIN = 32'h8000_0000;
    localparam logic [31:0] INT_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] UNS_MAX = 32'hFFFF_FFFF;

    typedef struct packed {
        logic        vld;
        t_cmd        cmd;
        logic        neg;
        logic        zero;
        logic        sat;
        logic [4:0]  sh;
        logic [31:0] val;
    } t_stage;
endpackage

// ===== rtl/ffpc_front.sv =====
// Stage one: decode the transaction and form magnitude and shift amount.
module ffpc_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_vld,
    input  logic [1:0]            i_command,
    input  logic [31:0]           i_operand,
    output ffpc_pkg::t_stage      o_stage
);
    import ffpc_pkg::*;

    t_stage n_stage;
    t_stage r_stage;
    logic [6:0] exp_f;

    always_comb begin
        n_stage      = '0;
        n_stage.vld  = i_vld;
        n_stage.cmd  = t_cmd'(i_command);
        exp_f        = i_operand[6:0];
        if (i_command[1] == 1'b0) begin
            n_stage.neg  = (n_stage.cmd == CMD_S2F) && i_operand[31];
            n_stage.val  = n_stage.neg ? (32'd0 - i_operand) : i_operand;
            n_stage.zero = (i_operand == 32'd0);
        end else begin
            n_stage.neg  = i_operand[7];
            n_stage.val  = {i_operand[31:8], 8'd0};
            n_stage.zero = (exp_f <= BIAS) || (i_operand[31:8] == 24'd0);
            n_stage.sat  = exp_f > TOP_EXP;
            n_stage.sh   = 5'(TOP_EXP - exp_f);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.vld <= 1'b0;
        end else begin
            r_stage.vld <= n_stage.vld;
        end
        r_stage.cmd  <= n_stage.cmd;
        r_stage.neg  <= n_stage.neg;
        r_stage.zero <= n_stage.zero;
        r_stage.sat  <= n_stage.sat;
        r_stage.sh   <= n_stage.sh;
        r_stage.val  <= n_stage.val;
    end

    assign o_stage = r_stage;
endmodule

// ===== rtl/ffpc_shift.sv =====
// Stage two: leading-zero count and normalising left shift for integers, right shift for floats.
module ffpc_shift (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ffpc_pkg::t_stage      i_stage,
    output ffpc_pkg::t_stage      o_stage
);
    import ffpc_pkg::*;

    t_stage n_stage;
    t_stage r_stage;
    logic [4:0] lz;

    always_comb begin
        lz = 5'd0;
        for (int i = 0; i < 32; i++) begin
            if (i_stage.val[i]) begin
                lz = 5'(31 - i);
            end
        end
        n_stage = i_stage;
        if (i_stage.cmd[1] == 1'b0) begin
            n_stage.sh  = lz;
            n_stage.val = i_stage.val << lz;
        end else begin
            n_stage.val = i_stage.val >> i_stage.sh;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.vld <= 1'b0;
        end else begin
            r_stage.vld <= n_stage.vld;
        end
        r_stage.cmd  <= n_stage.cmd;
        r_stage.neg  <= n_stage.neg;
        r_stage.zero <= n_stage.zero;
        r_stage.sat  <= n_stage.sat;
        r_stage.sh   <= n_stage.sh;
        r_stage.val  <= n_stage.val;
    end

    assign o_stage = r_stage;
endmodule

// ===== rtl/ffpc_pack.sv =====
// Stage three: pack the float word or saturate and sign the integer.
module ffpc_pack (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ffpc_pkg::t_stage      i_stage,
    output logic                  o_done,
    output logic [31:0]           o_result
);
    import ffpc_pkg::*;

    logic [31:0] n_res;
    logic [31:0] r_res;
    logic        r_done;
    logic [6:0]  e;

    always_comb begin
        e = 7'(TOP_EXP - {2'd0, i_stage.sh});
        n_res = 32'd0;
        if (i_stage.zero) begin
            n_res = 32'd0;
        end else begin
            case (i_stage.cmd)
                CMD_S2F, CMD_U2F: begin
                    n_res = {i_stage.val[31:8], i_stage.neg, e};
                end
                CMD_F2S: begin
                    if (i_stage.sat || i_stage.val[31]) begin
                        n_res = i_stage.neg ? INT_MIN : INT_MAX;
                    end else begin
                        n_res = i_stage.neg ? (32'd0 - i_stage.val) : i_stage.val;
                    end
                end
                default: begin
                    n_res = i_stage.sat ? UNS_MAX : i_stage.val;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_stage.vld;
        end
        r_res <= n_res;
    end

    assign o_done   = r_done;
    assign o_result = r_res;
endmodule

// ===== rtl/ffp_integer_converter_core.sv =====
// Top level: three-stage integer and fast floating point converter.
// One transaction is taken in every cycle (busy stays low); its result
// appears on o_result with o_done high once it has passed the decode,
// shift and pack register stages. No stalls are possible.
module ffp_integer_converter_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_command,
    input  logic [31:0] i_operand,
    output logic        o_done,
    output logic [31:0] o_result
);
    import ffpc_pkg::*;

    t_stage s1;
    t_stage s2;

    assign busy = 1'b0;

    ffpc_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(start),
        .i_command(i_command), .i_operand(i_operand), .o_stage(s1)
    );
    ffpc_shift u_shift (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_stage(s1), .o_stage(s2)
    );
    ffpc_pack u_pack (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_stage(s2),
        .o_done(o_done), .o_result(o_result)
    );
endmodule

// ===== rtl/ffpc_checker.sv =====
// Checker: port-level properties of the converter, bound to the top level.
module ffpc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic [1:0]  i_command,
    input logic [31:0] i_operand,
    input logic        o_done,
    input logic [31:0] o_result
);
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |-> ##3 o_done) else $error("result missing");
    a_nospur: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start, 3)) else $error("spurious result");
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && i_command[1] && i_operand[31:8] == 24'd0 |-> ##3 o_result == 32'd0)
        else $error("zero mantissa not zero");
    a_izero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !i_command[1] && i_operand == 32'd0 |-> ##3 o_result == 32'd0)
        else $error("zero integer not zero");
endmodule

bind ffp_integer_converter_core ffpc_checker u_ffpc_checker (.*);
